// ===== design/extremum_detector_with_area_unit_assert.svh =====
// assertion macros for the extremum detector checker
// no dependencies; included by files that hold concurrent assertions
`ifndef EXTREMUM_DETECTOR_WITH_AREA_UNIT_ASSERT_SVH
`define EXTREMUM_DETECTOR_WITH_AREA_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define EDWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define EDWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/edwa_pkg.sv =====
// shared types and constants of the extremum detector
// no dependencies
`default_nettype none

package edwa_pkg;

	localparam int SampleBits    = 16;
	localparam int PosW          = 16;
	localparam int SumW          = 33;
	localparam int TermW         = SampleBits + 1;
	localparam int AreaW         = 34;
	localparam int MaxLenDefault = 65536;
	localparam int QueueDepth    = 4;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_PEAK  = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SLOPE_NONE = 2'd0,
		SLOPE_RISE = 2'd1,
		SLOPE_FALL = 2'd2
	} slope_t;

	// area is rebuilt later as 2*sum + term - base
	typedef struct packed {
		kind_t                         kind;
		logic [PosW-1:0]               position;
		logic signed [SampleBits-1:0]  level;
		logic signed [SumW-1:0]        sum;
		logic signed [TermW-1:0]       term;
		logic signed [SampleBits-1:0]  base;
		logic                          is_max;
		logic                          final_event;
		logic                          error;
	} edwa_event_t;

endpackage

`default_nettype wire

// ===== design/edwa_front.sv =====
// front part: takes samples, tracks slope and emits up to two event requests
// depends on edwa_pkg
`default_nettype none

module edwa_front
	import edwa_pkg::*;
#(
	parameter int MaxLen = MaxLenDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic signed [SampleBits-1:0] sample,
	input  wire logic                         last,
	output      logic [1:0]                   wr_cnt,
	output      edwa_event_t                  ev0,
	output      edwa_event_t                  ev1
);

	localparam int CntW  = $clog2(MaxLen + 1);
	localparam int WideW = (CntW > PosW) ? CntW : PosW;

	logic [CntW-1:0]              cnt_q;
	logic                         ovf_q;
	logic                         started_q;
	logic                         lastpol_q;
	slope_t                       dir_q;
	logic signed [SampleBits-1:0] first_q;
	logic signed [SampleBits-1:0] prev_q;
	logic signed [SumW-1:0]       sum_q;

	logic              ovf;
	logic              rising;
	logic              falling;
	logic              c_start;
	logic              c_peak;
	logic              c_flat;
	logic              have_pre;
	logic [WideW-1:0]  idx_wide;
	logic [PosW-1:0]   idx_pos;
	edwa_event_t       ev_pre;
	edwa_event_t       ev_end;
	edwa_event_t       ev_err;

	always_comb begin
		ovf      = ovf_q || (cnt_q >= CntW'(MaxLen));
		rising   = sample > prev_q;
		falling  = sample < prev_q;
		c_start  = !started_q && (sample != first_q);
		c_peak   = (rising && dir_q == SLOPE_FALL) || (falling && dir_q == SLOPE_RISE);
		// all samples so far equal the first one
		c_flat   = last && !started_q && !c_start;
		have_pre = c_start || c_peak || c_flat;
		idx_wide = WideW'(cnt_q);
		idx_pos  = idx_wide[PosW-1:0];

		ev_pre.kind        = KIND_START;
		ev_pre.position    = '0;
		ev_pre.level       = first_q;
		ev_pre.sum         = '0;
		ev_pre.term        = TermW'(first_q);
		ev_pre.base        = first_q;
		ev_pre.is_max      = c_start && (sample < first_q);
		ev_pre.final_event = 1'b0;
		ev_pre.error       = 1'b0;
		if (!c_start && c_peak) begin
			ev_pre.kind     = KIND_PEAK;
			ev_pre.position = idx_pos - PosW'(1);
			ev_pre.level    = prev_q;
			ev_pre.sum      = sum_q;
			ev_pre.term     = -TermW'(prev_q);
			ev_pre.is_max   = falling;
		end

		ev_end.kind        = KIND_END;
		ev_end.position    = idx_pos;
		ev_end.level       = sample;
		ev_end.sum         = sum_q;
		ev_end.term        = TermW'(sample);
		ev_end.base        = first_q;
		ev_end.is_max      = have_pre ? !ev_pre.is_max : !lastpol_q;
		ev_end.final_event = 1'b1;
		ev_end.error       = 1'b0;

		ev_err             = '0;
		ev_err.kind        = KIND_END;
		ev_err.final_event = 1'b1;
		ev_err.error       = 1'b1;

		wr_cnt = 2'd0;
		ev0    = ev_err;
		ev1    = ev_end;
		if (accept) begin
			if (ovf || cnt_q == '0) begin
				wr_cnt = last ? 2'd1 : 2'd0;
			end else if (have_pre) begin
				ev0    = ev_pre;
				wr_cnt = last ? 2'd2 : 2'd1;
			end else begin
				ev0    = ev_end;
				wr_cnt = last ? 2'd1 : 2'd0;
			end
		end
	end

	// trace control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			started_q <= 1'b0;
			lastpol_q <= 1'b0;
			dir_q     <= SLOPE_NONE;
		end else if (accept) begin
			if (last) begin
				cnt_q     <= '0;
				ovf_q     <= 1'b0;
				started_q <= 1'b0;
				lastpol_q <= 1'b0;
				dir_q     <= SLOPE_NONE;
			end else if (ovf) begin
				ovf_q <= 1'b1;
			end else if (cnt_q == '0) begin
				cnt_q <= CntW'(1);
			end else begin
				cnt_q     <= cnt_q + CntW'(1);
				started_q <= started_q || c_start;
				if (have_pre)
					lastpol_q <= ev_pre.is_max;
				if (rising)
					dir_q <= SLOPE_RISE;
				else if (falling)
					dir_q <= SLOPE_FALL;
			end
		end
	end

	// sample history, valid only while a trace is open
	always_ff @(posedge clk) begin
		if (accept && !last && !ovf) begin
			if (cnt_q == '0) begin
				first_q <= sample;
				prev_q  <= sample;
				sum_q   <= SumW'(sample);
			end else begin
				prev_q <= sample;
				sum_q  <= sum_q + SumW'(sample);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/edwa_queue.sv =====
// event queue between front and back; takes up to two requests a cycle
// depends on edwa_pkg
`default_nettype none

module edwa_queue
	import edwa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  wr_cnt,
	input  wire edwa_event_t wr0,
	input  wire edwa_event_t wr1,
	output      logic        full,
	input  wire logic        take,
	output      logic        rd_valid,
	output      edwa_event_t rd_data
);

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	edwa_event_t      mem [QueueDepth];
	logic [PtrW-1:0]  wp_q;
	logic [PtrW-1:0]  rp_q;
	logic [CntW-1:0]  cnt_q;

	assign full     = cnt_q > CntW'(QueueDepth - 2);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PtrW'(wr_cnt);
			rp_q  <= rp_q + PtrW'(take);
			cnt_q <= cnt_q + CntW'(wr_cnt) - CntW'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0)
			mem[wp_q] <= wr0;
		if (wr_cnt == 2'd2)
			mem[wp_q + PtrW'(1)] <= wr1;
	end

endmodule

`default_nettype wire

// ===== design/edwa_back.sv =====
// back part: finishes the area sum and holds the result for the consumer
// depends on edwa_pkg
`default_nettype none

module edwa_back
	import edwa_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire edwa_event_t                   q_data,
	output      logic                          q_take,
	input  wire logic                          pop,
	output      logic                          empty,
	output      logic [1:0]                    kind,
	output      logic [PosW-1:0]               position,
	output      logic signed [SampleBits-1:0]  level,
	output      logic signed [AreaW-1:0]       area_twice,
	output      logic                          is_max,
	output      logic                          final_event,
	output      logic                          error
);

	logic                    valid_q;
	logic signed [AreaW-1:0] area;

	assign q_take = q_valid && (!valid_q || pop);
	assign empty  = !valid_q;
	assign area   = $signed({q_data.sum, 1'b0}) + AreaW'(q_data.term)
	                - AreaW'(q_data.base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_take)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			kind        <= q_data.kind;
			position    <= q_data.position;
			level       <= q_data.level;
			area_twice  <= area;
			is_max      <= q_data.is_max;
			final_event <= q_data.final_event;
			error       <= q_data.error;
		end
	end

endmodule

`default_nettype wire

// ===== design/extremum_detector_with_area_unit.sv =====
// top level of the extremum detector with trapezoid area
// depends on edwa_pkg, edwa_front, edwa_queue, edwa_back
//
//  channel   handshake           payload
//  input     push / full         sample, last
//  result    pop / empty         kind, position, level, area_twice,
//                                is_max, final_event, error
//
// one sample is taken per cycle while full is low; the front part
// classifies it in the cycle it is taken and writes zero, one or two
// event requests to a four-entry queue
// the result register loads one event per cycle while it is empty or
// popped; each event passes through a queue entry and then the result
// register, and the two events of a sample load one after the other
// full rises when fewer than two queue entries are free
// reset clears the trace state, the queue and the result valid flag
`default_nettype none

module extremum_detector_with_area_unit
	import edwa_pkg::*;
#(
	parameter int MaxLen = MaxLenDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output      logic                          full,
	input  wire logic signed [SampleBits-1:0]  sample,
	input  wire logic                          last,
	output      logic                          empty,
	input  wire logic                          pop,
	output      logic [1:0]                    kind,
	output      logic [PosW-1:0]               position,
	output      logic signed [SampleBits-1:0]  level,
	output      logic signed [AreaW-1:0]       area_twice,
	output      logic                          is_max,
	output      logic                          final_event,
	output      logic                          error
);

	logic        accept;
	logic [1:0]  wr_cnt;
	edwa_event_t ev0;
	edwa_event_t ev1;
	logic        q_take;
	logic        q_valid;
	edwa_event_t q_data;

	// a sample request is taken whenever the queue has room for two events
	assign accept = push && !full;

	// slope tracking, sentinels and overflow handling
	edwa_front #(
		.MaxLen (MaxLen)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.last   (last),
		.wr_cnt (wr_cnt),
		.ev0    (ev0),
		.ev1    (ev1)
	);

	// decouples the front from result backpressure
	edwa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (wr_cnt),
		.wr0      (ev0),
		.wr1      (ev1),
		.full     (full),
		.take     (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	// area completion and result register
	edwa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_take      (q_take),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.position    (position),
		.level       (level),
		.area_twice  (area_twice),
		.is_max      (is_max),
		.final_event (final_event),
		.error       (error)
	);

endmodule

`default_nettype wire

// ===== design/edwa_checker.sv =====
// port-level checks of the extremum detector, bound to the top level
// depends on edwa_pkg and the assertion macro header
`default_nettype none
`include "extremum_detector_with_area_unit_assert.svh"

module edwa_checker
	import edwa_pkg::*;
(
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          empty,
	input wire logic                          pop,
	input wire logic [1:0]                    kind,
	input wire logic [PosW-1:0]               position,
	input wire logic signed [SampleBits-1:0]  level,
	input wire logic signed [AreaW-1:0]       area_twice,
	input wire logic                          is_max,
	input wire logic                          final_event,
	input wire logic                          error
);

	localparam int ResW = 2 + PosW + SampleBits + AreaW + 3;

	logic [ResW-1:0] res_bits;
	logic            err_shape;
	logic            start_shape;

	// every result field, watched as one word
	assign res_bits    = {kind, position, level, area_twice, is_max, final_event, error};
	assign err_shape   = final_event && kind == KIND_END && position == '0
	                     && area_twice == '0 && level == '0 && !is_max;
	assign start_shape = position == '0 && area_twice == '0 && !final_event && !error;

	// a waiting result holds while the consumer stalls
	`EDWA_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(res_bits), "result moved")

	// an error result is a bare end of trace
	`EDWA_ASSERT_NOW(a_err, clk, arst_n, !empty && error, err_shape, "malformed error result")

	// only the end sentinel closes a trace
	`EDWA_ASSERT_NOW(a_final, clk, arst_n, !empty && final_event, kind == KIND_END, "final not end")

	// start sentinel sits at index zero with no area
	`EDWA_ASSERT_NOW(a_start, clk, arst_n, !empty && kind == KIND_START, start_shape, "bad start event")

	// interior extrema never close a trace
	`EDWA_ASSERT_NOW(a_peak, clk, arst_n, !empty && kind == KIND_PEAK, !final_event && !error, "bad peak")

endmodule

bind extremum_detector_with_area_unit edwa_checker u_edwa_checker (.*);

`default_nettype wire
